@@ hdl/swfe_pkg.sv @@
package swfe_pkg;

    // Field widths fixed by the frame format.
    localparam int BYTE_W     = 8;
    localparam int SYNC_W     = 16;
    localparam int FLEN_W     = 8;
    localparam int TIME_W     = 32;
    localparam int COUNT_W    = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    // Register reset values.
    localparam logic [SYNC_W-1:0] SYNC_WORD_RESET    = 16'h7BFE;
    localparam logic [FLEN_W-1:0] FRAME_LENGTH_RESET = 8'd76;

    // Offset of the first byte after the sync word.
    localparam logic [FLEN_W-1:0] OFS_AFTER_SYNC = 8'd2;

    // Byte offsets of the captured fields, little-endian.
    localparam logic [FLEN_W-1:0] OFS_TIME0 = 8'd4;
    localparam logic [FLEN_W-1:0] OFS_TIME1 = 8'd5;
    localparam logic [FLEN_W-1:0] OFS_TIME2 = 8'd6;
    localparam logic [FLEN_W-1:0] OFS_TIME3 = 8'd7;
    localparam logic [FLEN_W-1:0] OFS_RED0  = 8'd8;
    localparam logic [FLEN_W-1:0] OFS_RED1  = 8'd9;
    localparam logic [FLEN_W-1:0] OFS_BLUE0 = 8'd10;
    localparam logic [FLEN_W-1:0] OFS_BLUE1 = 8'd11;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYNC_WORD    = 8'd0,
        CFG_FRAME_LENGTH = 8'd1
    } cfg_index_t;

    typedef enum logic {
        ST_HUNT  = 1'b0,
        ST_FRAME = 1'b1
    } frame_state_t;

    typedef struct packed {
        logic signed [TIME_W-1:0] remaining_seconds;
        logic [COUNT_W-1:0]       red_count;
        logic [COUNT_W-1:0]       blue_count;
    } result_t;

    typedef struct packed {
        logic [SYNC_W-1:0] sync_word;
        logic [FLEN_W-1:0] frame_length;
    } cfg_t;

endpackage

@@ hdl/swfe_cfg_regs.sv @@
module swfe_cfg_regs
    import swfe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    logic [SYNC_W-1:0] sync_word_reg;
    logic [FLEN_W-1:0] frame_length_reg;

    // Writes are always taken; an unknown index is dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_word_reg    <= SYNC_WORD_RESET;
            frame_length_reg <= FRAME_LENGTH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SYNC_WORD:    sync_word_reg    <= cfg_data[SYNC_W-1:0];
                CFG_FRAME_LENGTH: frame_length_reg <= cfg_data[FLEN_W-1:0];
                default:          ;
            endcase
        end
    end

    assign cfg.sync_word    = sync_word_reg;
    assign cfg.frame_length = frame_length_reg;

endmodule

@@ hdl/swfe_in_reg.sv @@
module swfe_in_reg
    import swfe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic              consume,
    output logic              byte_valid,
    output logic [BYTE_W-1:0] byte_data
);

    logic              valid_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic              load;

    // The register frees up in the same cycle that its byte is consumed.
    assign in_stall = valid_reg && !consume;
    assign load     = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (consume)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= data_byte;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = byte_reg;

endmodule

@@ hdl/swfe_deframer.sv @@
module swfe_deframer
    import swfe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [BYTE_W-1:0] byte_data,
    input  cfg_t              cfg,
    output logic              res_valid,
    output result_t           res
);

    frame_state_t             state_reg, state_next;
    logic [BYTE_W-1:0]        previous_byte_reg, previous_byte_next;
    logic                     previous_valid_reg, previous_valid_next;
    logic [FLEN_W-1:0]        byte_position_reg, byte_position_next;
    logic [TIME_W-1:0]        time_capture_reg, time_capture_next;
    logic [COUNT_W-1:0]       red_capture_reg, red_capture_next;
    logic [COUNT_W-1:0]       blue_capture_reg, blue_capture_next;

    logic [TIME_W-1:0]        time_merged;
    logic [COUNT_W-1:0]       red_merged;
    logic [COUNT_W-1:0]       blue_merged;
    logic                     sync_hit;
    logic                     frame_end;

    // Drop the current byte into whichever field owns its offset.
    always_comb
    begin
        time_merged = time_capture_reg;
        red_merged  = red_capture_reg;
        blue_merged = blue_capture_reg;
        case (byte_position_reg)
            OFS_TIME0: time_merged[7:0]   = byte_data;
            OFS_TIME1: time_merged[15:8]  = byte_data;
            OFS_TIME2: time_merged[23:16] = byte_data;
            OFS_TIME3: time_merged[31:24] = byte_data;
            OFS_RED0:  red_merged[7:0]    = byte_data;
            OFS_RED1:  red_merged[15:8]   = byte_data;
            OFS_BLUE0: blue_merged[7:0]   = byte_data;
            OFS_BLUE1: blue_merged[15:8]  = byte_data;
            default:   ;
        endcase
    end

    assign sync_hit  = previous_valid_reg && ({byte_data, previous_byte_reg} == cfg.sync_word);
    assign frame_end = ({1'b0, byte_position_reg} + 9'd1) >= {1'b0, cfg.frame_length};

    always_comb
    begin
        state_next          = state_reg;
        previous_byte_next  = previous_byte_reg;
        previous_valid_next = previous_valid_reg;
        byte_position_next  = byte_position_reg;
        time_capture_next   = time_capture_reg;
        red_capture_next    = red_capture_reg;
        blue_capture_next   = blue_capture_reg;
        res_valid           = 1'b0;
        if (step)
        begin
            unique case (state_reg)
                ST_HUNT:
                begin
                    if (sync_hit)
                    begin
                        state_next          = ST_FRAME;
                        byte_position_next  = OFS_AFTER_SYNC;
                        previous_valid_next = 1'b0;
                        previous_byte_next  = '0;
                        time_capture_next   = '0;
                        red_capture_next    = '0;
                        blue_capture_next   = '0;
                    end
                    else
                    begin
                        previous_byte_next  = byte_data;
                        previous_valid_next = 1'b1;
                    end
                end
                ST_FRAME:
                begin
                    time_capture_next = time_merged;
                    red_capture_next  = red_merged;
                    blue_capture_next = blue_merged;
                    if (frame_end)
                    begin
                        res_valid           = 1'b1;
                        state_next          = ST_HUNT;
                        byte_position_next  = '0;
                        previous_valid_next = 1'b0;
                        previous_byte_next  = '0;
                    end
                    else
                    begin
                        byte_position_next = byte_position_reg + 8'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    // The result carries the last byte of the frame as well.
    assign res.remaining_seconds = time_merged;
    assign res.red_count         = red_merged;
    assign res.blue_count        = blue_merged;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_HUNT;
            previous_byte_reg  <= '0;
            previous_valid_reg <= 1'b0;
            byte_position_reg  <= '0;
            time_capture_reg   <= '0;
            red_capture_reg    <= '0;
            blue_capture_reg   <= '0;
        end
        else
        begin
            state_reg          <= state_next;
            previous_byte_reg  <= previous_byte_next;
            previous_valid_reg <= previous_valid_next;
            byte_position_reg  <= byte_position_next;
            time_capture_reg   <= time_capture_next;
            red_capture_reg    <= red_capture_next;
            blue_capture_reg   <= blue_capture_next;
        end
    end

endmodule

@@ hdl/swfe_out_reg.sv @@
module swfe_out_reg
    import swfe_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t res,
    input  logic    out_stall,
    output logic    free,
    output logic    out_valid,
    output result_t out_res
);

    logic    valid_reg;
    result_t res_reg;

    // A new result may enter when the register is empty or is being taken now.
    assign free = !valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

@@ hdl/sync_word_frame_extractor_top.sv @@
// Channel   Direction  Handshake              Payload
// input     in         in_valid / in_stall    data_byte[7:0]
// output    out        out_valid / out_stall  remaining_seconds[31:0] signed,
//                                             red_count[15:0], blue_count[15:0]
// config    in         cfg_valid / cfg_ready  cfg_index[7:0], cfg_data[15:0]
//
// One byte is taken per clock while in_stall is low. A byte is processed in a cycle in
// which it sits in the input register and the result register is free; the result of a
// frame's last byte is loaded into the result register by that step and then shows on the output.
// The sustained rate of one byte per cycle, while neither side stalls, is set by the
// single deframing step between the input register and the result register.
// rst_n clears all control state asynchronously and restores the register defaults.
// While a result sits unclaimed under out_stall, the byte in the input register waits,
// and in_stall rises once that register is also full.
module sync_word_frame_extractor_top
    import swfe_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [BYTE_W-1:0]        data_byte,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [TIME_W-1:0] remaining_seconds,
    output logic [COUNT_W-1:0]       red_count,
    output logic [COUNT_W-1:0]       blue_count,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data
);

    cfg_t              cfg;
    logic              byte_valid;
    logic [BYTE_W-1:0] byte_data;
    logic              out_free;
    logic              step;
    logic              res_valid;
    result_t           res;
    result_t           out_res;

    // Configuration registers. Writes are accepted on every cycle.
    swfe_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Input register: holds one byte transfer until the deframer takes it.
    swfe_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .consume    (step),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    // The deframer steps only when the result register can take whatever it emits,
    // so no result is ever lost or overwritten.
    assign step = byte_valid && out_free;

    // Sync hunt, byte counting and field capture.
    swfe_deframer u_deframer (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .byte_data (byte_data),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    // Result register: decouples the output handshake from the processing step.
    swfe_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_valid),
        .res       (res),
        .out_stall (out_stall),
        .free      (out_free),
        .out_valid (out_valid),
        .out_res   (out_res)
    );

    assign remaining_seconds = out_res.remaining_seconds;
    assign red_count         = out_res.red_count;
    assign blue_count        = out_res.blue_count;

endmodule

@@ hdl/swfe_checker.sv @@
module swfe_checker
    import swfe_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_stall,
    input logic                     out_valid,
    input logic                     out_stall,
    input logic signed [TIME_W-1:0] remaining_seconds,
    input logic [COUNT_W-1:0]       red_count,
    input logic [COUNT_W-1:0]       blue_count,
    input logic                     cfg_valid,
    input logic                     cfg_ready
);

    // A stalled result holds its value until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(remaining_seconds)
            && $stable(red_count) && $stable(blue_count))
        else $error("stalled result changed");

    // With the result register empty, the input side never stalls.
    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty result register");

    // A new result follows a cycle in which the input register was moving.
    a_result_needs_step: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_stall))
        else $error("result appeared without a processing step");

    // Configuration writes are never held off.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind sync_word_frame_extractor_top swfe_checker u_swfe_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .remaining_seconds (remaining_seconds),
    .red_count         (red_count),
    .blue_count        (blue_count),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready)
);

@@ tb/tb_sync_word_frame_extractor_top.sv @@
module tb_sync_word_frame_extractor_top;
    import swfe_pkg::*;

    localparam int CLK_PERIOD       = 10;
    localparam int RESET_CYCLES     = 12;
    // The block holds a byte in its input register and a result in its output register.
    // The quiet tail covers a byte that is still on its way through after the last transfer.
    localparam int TAIL_CYCLES      = 8;
    localparam int CYCLE_LIMIT      = 400000;
    localparam int DIRECTED_ROWS    = 9;
    localparam int BYTES_PER_PHASE  = 120;
    localparam int FRAMES_PER_PHASE = 4;
    localparam int FIRST_SPARE_INDEX = CFG_FRAME_LENGTH + 1;

    // One row of the directed table. The frame is sent as a lead byte, the sync word and
    // then one byte per offset up to the end of the frame. Offsets outside the captured
    // fields carry the fill byte. Where typed is set, typed_frame is the result that the
    // row must produce, written out by hand.
    typedef struct packed {
        logic [SYNC_W-1:0]     sync_word;
        logic [CFG_DATA_W-1:0] length_data;
        logic [BYTE_W-1:0]     lead;
        logic [BYTE_W-1:0]     fill;
        logic [TIME_W-1:0]     time_field;
        logic [COUNT_W-1:0]    red_field;
        logic [COUNT_W-1:0]    blue_field;
        logic                  typed;
        result_t               typed_frame;
    } directed_case_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic [BYTE_W-1:0]        data_byte = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [TIME_W-1:0] remaining_seconds;
    logic [COUNT_W-1:0]       red_count;
    logic [COUNT_W-1:0]       blue_count;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [CFG_DATA_W-1:0]    cfg_data = '0;

    sync_word_frame_extractor_top dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .data_byte         (data_byte),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .remaining_seconds (remaining_seconds),
        .red_count         (red_count),
        .blue_count        (blue_count),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Deframer state as the testbench sees it. It starts from the reset state of the block
    // and moves one byte at a time, at the transfer of that byte into the block.
    logic [SYNC_W-1:0]  sync_cfg   = SYNC_WORD_RESET;
    logic [FLEN_W-1:0]  flen_cfg   = FRAME_LENGTH_RESET;
    frame_state_t       hunt_state = ST_HUNT;
    logic [BYTE_W-1:0]  prev_byte  = '0;
    logic               prev_held  = 1'b0;
    logic [FLEN_W-1:0]  frame_pos  = '0;
    logic [TIME_W-1:0]  time_acc   = '0;
    logic [COUNT_W-1:0] red_acc    = '0;
    logic [COUNT_W-1:0] blue_acc   = '0;

    // Frames that the block still owes, oldest first.
    result_t frames_due[$];
    result_t front_frame;

    // A hand-typed result replaces the computed one for the next frame that completes.
    logic    typed_pending = 1'b0;
    result_t typed_frame;

    directed_case_t directed_cases [DIRECTED_ROWS];

    int sender_idle_pct   = 0;
    int receiver_stall_pct = 0;
    int bytes_sent        = 0;
    int frames_predicted  = 0;
    int frames_checked    = 0;
    int hand_typed        = 0;
    int settings_written  = 0;
    int mismatch_count    = 0;
    int cycle_count       = 0;

    // Steps the deframer by one byte. Returns 1 when the byte closes a frame; the frame's
    // fields are then in frame.
    function automatic bit deframe_byte(input logic [BYTE_W-1:0] b, output result_t frame);
        logic [FLEN_W:0] next_pos;
        frame = '0;
        next_pos = {1'b0, frame_pos} + 1'b1;
        if (hunt_state == ST_HUNT)
        begin
            // The previous byte is the low half of the word, the new byte the high half,
            // so a match can start on the second byte of an earlier near miss.
            if (prev_held && {b, prev_byte} == sync_cfg)
            begin
                hunt_state = ST_FRAME;
                frame_pos  = OFS_AFTER_SYNC;
                prev_held  = 1'b0;
                prev_byte  = '0;
                time_acc   = '0;
                red_acc    = '0;
                blue_acc   = '0;
            end
            else
            begin
                prev_byte = b;
                prev_held = 1'b1;
            end
            return 1'b0;
        end
        if (frame_pos >= OFS_TIME0 && frame_pos <= OFS_TIME3)
            time_acc[8 * (frame_pos - OFS_TIME0) +: 8] = b;
        else if (frame_pos == OFS_RED0 || frame_pos == OFS_RED1)
            red_acc[8 * (frame_pos - OFS_RED0) +: 8] = b;
        else if (frame_pos == OFS_BLUE0 || frame_pos == OFS_BLUE1)
            blue_acc[8 * (frame_pos - OFS_BLUE0) +: 8] = b;
        // A frame length below three still lets one byte through after the sync word.
        if (next_pos >= {1'b0, flen_cfg})
        begin
            frame.remaining_seconds = time_acc;
            frame.red_count         = red_acc;
            frame.blue_count        = blue_acc;
            hunt_state = ST_HUNT;
            frame_pos  = '0;
            prev_held  = 1'b0;
            prev_byte  = '0;
            return 1'b1;
        end
        frame_pos = next_pos[FLEN_W-1:0];
        return 1'b0;
    endfunction

    function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] value);
        case (idx)
            CFG_SYNC_WORD:    sync_cfg = value;
            CFG_FRAME_LENGTH: flen_cfg = value[FLEN_W-1:0];
            default: ;
        endcase
    endfunction

    // Offers one byte, after a random idle stretch, and holds it until the transfer.
    // Valid is decided before the stall is looked at, and the byte stays put meanwhile.
    task automatic send_byte(input logic [BYTE_W-1:0] value);
        result_t frame;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= value;
        do @(posedge clk); while (in_stall);
        bytes_sent++;
        if (deframe_byte(value, frame))
        begin
            if (typed_pending)
            begin
                frames_due.push_back(typed_frame);
                typed_pending = 1'b0;
                hand_typed++;
            end
            else
            begin
                frames_due.push_back(frame);
            end
            frames_predicted++;
        end
    endtask

    // Lets the block run dry: no byte offered, every owed frame delivered, and a few
    // quiet cycles for a byte that closes no frame.
    task automatic drain();
        in_valid <= 1'b0;
        while (frames_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // Writes the sync word, the frame length and then a register index that does not
    // exist, which the block must ignore. Valid stays high across the three transfers.
    task automatic configure(input logic [SYNC_W-1:0] sync_value,
                             input logic [CFG_DATA_W-1:0] length_value);
        logic [CFG_IDX_W-1:0]  idx [3];
        logic [CFG_DATA_W-1:0] value [3];
        idx[0]   = CFG_SYNC_WORD;
        value[0] = sync_value;
        idx[1]   = CFG_FRAME_LENGTH;
        value[1] = length_value;
        idx[2]   = 8'($urandom_range(255, FIRST_SPARE_INDEX));
        value[2] = 16'($urandom_range(16'hFFFF));
        for (int k = 0; k < 3; k++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[k];
            cfg_data  <= value[k];
            do @(posedge clk); while (!cfg_ready);
            apply_register(idx[k], value[k]);
        end
        cfg_valid <= 1'b0;
        settings_written++;
    endtask

    // One stretch of random stream. Most stretches are whole frames behind a short run of
    // noise; the rest are sync words with a wrong second byte, or plain noise.
    task automatic send_burst();
        int after_sync;
        int kind;
        logic [BYTE_W-1:0] pay;
        after_sync = (flen_cfg < 3) ? 1 : flen_cfg - 2;
        kind = $urandom_range(99);
        if (kind < 80)
        begin
            repeat ($urandom_range(4)) send_byte(8'($urandom_range(255)));
            send_byte(sync_cfg[7:0]);
            send_byte(sync_cfg[15:8]);
            // Sync bytes are salted into the payload, where they must pass as data.
            for (int k = 0; k < after_sync; k++)
            begin
                if ($urandom_range(7) == 0)
                    pay = ($urandom_range(1) == 0) ? sync_cfg[7:0] : sync_cfg[15:8];
                else
                    pay = 8'($urandom_range(255));
                send_byte(pay);
            end
        end
        else if (kind < 90)
        begin
            send_byte(sync_cfg[7:0]);
            send_byte(sync_cfg[15:8] ^ 8'($urandom_range(255, 1)));
        end
        else
        begin
            repeat ($urandom_range(10, 1)) send_byte(8'($urandom_range(255)));
        end
    endtask

    // The receiver stalls at random, at the rate the current phase asks for.
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < receiver_stall_pct);

    // Every result transfer is held against the oldest frame still owed.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            frames_checked++;
            if (frames_due.size() == 0)
            begin
                $error("unexpected frame: remaining_seconds %0d, red_count %0d, blue_count %0d",
                       remaining_seconds, red_count, blue_count);
                mismatch_count++;
            end
            else
            begin
                front_frame = frames_due.pop_front();
                if (remaining_seconds !== front_frame.remaining_seconds)
                begin
                    $error("remaining_seconds: expected %0d, actual %0d",
                           $signed(front_frame.remaining_seconds), remaining_seconds);
                    mismatch_count++;
                end
                if (red_count !== front_frame.red_count)
                begin
                    $error("red_count: expected %0d, actual %0d",
                           front_frame.red_count, red_count);
                    mismatch_count++;
                end
                if (blue_count !== front_frame.blue_count)
                begin
                    $error("blue_count: expected %0d, actual %0d",
                           front_frame.blue_count, blue_count);
                    mismatch_count++;
                end
            end
        end
    end

    // A hung handshake or a frame that never comes ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d frames still owed",
                     cycle_count, frames_due.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        directed_case_t    dc;
        int                last_pos;
        logic [BYTE_W-1:0] b;
        logic [SYNC_W-1:0] sync_value;
        logic [FLEN_W-1:0] length_value;
        int                pick;
        int                bursts;
        int                start_bytes;
        int                start_frames;
        bit                first_segment;

        // Directed table: sync word, length data (the high byte is junk that the block
        // drops), lead byte, fill byte, time, red, blue, typed flag, typed result.
        // The first row runs on the register values from reset, with the most negative
        // time. A lead byte equal to the low sync byte makes the match overlap.
        directed_cases[0] = {SYNC_WORD_RESET, 8'h00, FRAME_LENGTH_RESET, 8'hFE, 8'h00,
                             32'h8000_0000, 16'hFFFF, 16'h0000,
                             1'b1, 32'h8000_0000, 16'hFFFF, 16'h0000};
        // An all-zero sync word with a zero lead byte matches one byte early, so the
        // frame slides by one byte and the computed result is used.
        directed_cases[1] = {16'h0000, 16'h000C, 8'h00, 8'h00,
                             32'h7FFF_FFFF, 16'h0000, 16'hFFFF,
                             1'b0, 64'h0};
        directed_cases[2] = {16'hFFFF, 16'hC30C, 8'h00, 8'hFF,
                             32'hFFFF_FFFF, 16'h0001, 16'h8000,
                             1'b1, 32'hFFFF_FFFF, 16'h0001, 16'h8000};
        // Frame lengths of three and zero end the frame on the byte after the sync word,
        // before any field is reached, so every field reads zero.
        directed_cases[3] = {16'h1234, 16'h0003, 8'h00, 8'h00,
                             32'h1111_1111, 16'h2222, 16'h3333,
                             1'b1, 64'h0};
        directed_cases[4] = {16'h1234, 16'hAB00, 8'h00, 8'h00,
                             32'h1111_1111, 16'h2222, 16'h3333,
                             1'b1, 64'h0};
        // A length of seven cuts the time field after three of its bytes.
        directed_cases[5] = {16'h1234, 16'h0007, 8'h00, 8'h00,
                             32'h4433_2211, 16'h5566, 16'h7788,
                             1'b0, 64'h0};
        // Sync bytes inside the frame are data. The frame ends on the low sync byte,
        // and the next row's lead byte is the high sync byte, which must not complete
        // a match since the block forgets the last byte of a frame.
        directed_cases[6] = {16'h1234, 16'h000C, 8'h00, 8'h34,
                             32'h1234_1234, 16'h1234, 16'h3412,
                             1'b1, 32'h1234_1234, 16'h1234, 16'h3412};
        directed_cases[7] = {16'h1234, 16'h000C, 8'h12, 8'h00,
                             32'h0000_0001, 16'h0002, 16'h0003,
                             1'b1, 32'h0000_0001, 16'h0002, 16'h0003};
        // Equal halves in the sync word: a run of that byte matches as early as it can.
        directed_cases[8] = {16'h5A5A, 16'h000D, 8'h5A, 8'h5A,
                             32'h5A5A_5A5A, 16'h5A5A, 16'h5A5A,
                             1'b0, 64'h0};

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, with no idling on either side. A new register setting is only
        // written once the block has run dry.
        for (int row = 0; row < DIRECTED_ROWS; row++)
        begin
            dc = directed_cases[row];
            if (dc.sync_word != sync_cfg || dc.length_data[FLEN_W-1:0] != flen_cfg)
            begin
                drain();
                configure(dc.sync_word, dc.length_data);
            end
            typed_pending = dc.typed;
            typed_frame   = dc.typed_frame;
            send_byte(dc.lead);
            send_byte(dc.sync_word[7:0]);
            send_byte(dc.sync_word[15:8]);
            last_pos = (dc.length_data[FLEN_W-1:0] < 3) ? 2 : dc.length_data[FLEN_W-1:0] - 1;
            for (int p = 2; p <= last_pos; p++)
            begin
                if (p >= OFS_TIME0 && p <= OFS_TIME3)
                    b = dc.time_field[8 * (p - OFS_TIME0) +: 8];
                else if (p == OFS_RED0 || p == OFS_RED1)
                    b = dc.red_field[8 * (p - OFS_RED0) +: 8];
                else if (p == OFS_BLUE0 || p == OFS_BLUE1)
                    b = dc.blue_field[8 * (p - OFS_BLUE0) +: 8];
                else
                    b = dc.fill;
                send_byte(b);
            end
        end
        typed_pending = 1'b0;

        // Random part in three phases: a slow receiver, then a slow sender, then both
        // at full rate. Each phase walks through one or more register settings.
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    sender_idle_pct    = 28;
                    receiver_stall_pct = 71;
                end
                1:
                begin
                    sender_idle_pct    = 71;
                    receiver_stall_pct = 28;
                end
                default:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
            endcase
            start_bytes   = bytes_sent;
            start_frames  = frames_predicted;
            first_segment = 1'b1;
            while (bytes_sent - start_bytes < BYTES_PER_PHASE
                   || frames_predicted - start_frames < FRAMES_PER_PHASE)
            begin
                drain();
                pick = $urandom_range(9);
                case (pick)
                    0: sync_value = 16'h0000;
                    1: sync_value = 16'hFFFF;
                    2: sync_value = SYNC_WORD_RESET;
                    3:
                    begin
                        b = 8'($urandom_range(255));
                        sync_value = {b, b};
                    end
                    default: sync_value = 16'($urandom_range(16'hFFFF));
                endcase
                // Most settings use short frames; the longest frame is run once.
                pick = $urandom_range(19);
                if (pick == 0)
                    length_value = FRAME_LENGTH_RESET;
                else if (pick < 5)
                    length_value = 8'($urandom_range(11));
                else
                    length_value = 8'($urandom_range(24, 12));
                if (phase == 2 && first_segment)
                    length_value = 8'd255;
                configure(sync_value, {8'($urandom_range(255)), length_value});
                bursts = (flen_cfg > 40) ? 1 : $urandom_range(8, 3);
                repeat (bursts) send_burst();
                first_segment = 1'b0;
            end
        end

        drain();
        $display("Streamed %0d bytes through %0d register settings; %0d frames checked,",
                 bytes_sent, settings_written, frames_checked);
        $display("%0d of them against hand-typed results, %0d mismatches.",
                 hand_typed, mismatch_count);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
